// ----- hw/rtl/gdtc_pkg.sv -----
// shared types and constants for the greedy distance-two coloring unit
// no dependencies
package gdtc_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxDegree   = 8;
  localparam int unsigned VidW        = 6;
  localparam int unsigned ColW        = 6;
  localparam int unsigned CntW        = 4;
  localparam int unsigned SlotW       = 3;
  localparam int unsigned AddrW       = VidW + SlotW;
  localparam int unsigned MarkSlots   = MaxDegree * (MaxDegree - 1) + 1;
  localparam int unsigned NumW        = 7;

  localparam logic CmdEdge = 1'b0;
  localparam logic CmdRun  = 1'b1;

  typedef enum logic [4:0] {
    StIdle,
    StEdgeRdA,
    StEdgeRdB,
    StEdgeEval,
    StEdgeOut,
    StEdgeWr2,
    StClear,
    StVtxStart,
    StVtxCnt,
    StOuterRd,
    StOuterWait,
    StOuterCnt,
    StInnerRd,
    StInnerWait,
    StInnerMark,
    StPick,
    StEmitRd,
    StEmit
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic cnt_rd_a;
    logic cnt_rd_b;
    logic take_ca;
    logic take_cb;
    logic edge_wr1;
    logic edge_wr2;
    logic run_start;
    logic vtx_init;
    logic take_dv;
    logic outer_rd;
    logic outer_take;
    logic take_dw;
    logic inner_rd;
    logic inner_take;
    logic inner_mark;
    logic pick;
    logic emit_rd;
    logic emit_load;
    logic emit_next;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_run;
    logic edge_bad;
    logic no_vertices;
    logic outer_done;
    logic inner_done;
    logic vtx_last;
  } stat_t;

endpackage

// ----- hw/rtl/gdtc_ram.sv -----
// generic ram with one write port and one registered read port
// no dependencies
module gdtc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hw/rtl/gdtc_ctrl.sv -----
// controller state machine for the coloring unit
// depends on gdtc_pkg
module gdtc_ctrl import gdtc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:      if (in_valid_i) state_d = StEdgeRdA;
      StEdgeRdA: begin
        if (stat_i.is_run) state_d = StClear;
        else state_d = StEdgeRdB;
      end
      StEdgeRdB:   state_d = StEdgeEval;
      StEdgeEval:  state_d = StEdgeOut;
      StEdgeOut: begin
        if (out_free_i) begin
          if (stat_i.edge_bad) state_d = StIdle;
          else state_d = StEdgeWr2;
        end
      end
      StEdgeWr2:   state_d = StIdle;
      StClear: begin
        if (stat_i.no_vertices) state_d = StIdle;
        else state_d = StVtxStart;
      end
      StVtxStart:  state_d = StVtxCnt;
      StVtxCnt:    state_d = StOuterRd;
      StOuterRd: begin
        if (stat_i.outer_done) state_d = StPick;
        else state_d = StOuterWait;
      end
      StOuterWait: state_d = StOuterCnt;
      StOuterCnt:  state_d = StInnerRd;
      StInnerRd: begin
        if (stat_i.inner_done) state_d = StOuterRd;
        else state_d = StInnerWait;
      end
      StInnerWait: state_d = StInnerMark;
      StInnerMark: state_d = StInnerRd;
      StPick: begin
        if (stat_i.vtx_last) state_d = StEmitRd;
        else state_d = StVtxStart;
      end
      StEmitRd:    if (out_free_i) state_d = StEmit;
      StEmit: begin
        if (stat_i.vtx_last) state_d = StIdle;
        else state_d = StEmitRd;
      end
      default:     state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        ctrl_o.latch_in = in_valid_i;
      end
      StEdgeRdA:   ctrl_o.cnt_rd_a = 1'b1;
      StEdgeRdB: begin
        ctrl_o.take_ca = 1'b1;
        ctrl_o.cnt_rd_b = 1'b1;
      end
      StEdgeEval:  ctrl_o.take_cb = 1'b1;
      StEdgeOut: begin
        ctrl_o.edge_wr1 = out_free_i & ~stat_i.edge_bad;
        ctrl_o.emit_load = out_free_i;
      end
      StEdgeWr2:   ctrl_o.edge_wr2 = 1'b1;
      StClear:     ctrl_o.run_start = 1'b1;
      StVtxStart:  ctrl_o.vtx_init = 1'b1;
      StVtxCnt:    ctrl_o.take_dv = 1'b1;
      StOuterRd:   ctrl_o.outer_rd = ~stat_i.outer_done;
      StOuterWait: ctrl_o.outer_take = 1'b1;
      StOuterCnt:  ctrl_o.take_dw = 1'b1;
      StInnerRd:   ctrl_o.inner_rd = ~stat_i.inner_done;
      StInnerWait: ctrl_o.inner_take = 1'b1;
      StInnerMark: ctrl_o.inner_mark = 1'b1;
      StPick:      ctrl_o.pick = 1'b1;
      StEmitRd:    ctrl_o.emit_rd = out_free_i;
      StEmit: begin
        ctrl_o.emit_load = 1'b1;
        ctrl_o.emit_next = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ----- hw/rtl/gdtc_dp.sv -----
// datapath: adjacency, count and color memories, mark vector and output beat
// depends on gdtc_pkg and gdtc_ram
module gdtc_dp import gdtc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_i,
  input  logic [VidW-1:0]  va_i,
  input  logic [VidW-1:0]  vb_i,
  input  logic             cfg_we_i,
  input  logic [NumW-1:0]  cfg_data_i,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_free_o,
  output logic [VidW-1:0]  out_vid_o,
  output logic [ColW-1:0]  out_color_o,
  output logic             out_status_o,
  output logic             out_last_o
);
  logic [NumW-1:0] count_q;
  logic            cmd_q;
  logic [VidW-1:0] a_q, b_q;
  logic [CntW-1:0] ca_q, cb_q;
  logic [MaxVertices-1:0] cnt_vld_q;
  logic            cnt_vld_rd_q;
  logic [MarkSlots-1:0] marks_q;
  logic [VidW-1:0] v_q, w_q, x_q;
  logic [CntW-1:0] j_q, k_q, dv_q, dw_q;
  logic            ov_q;
  logic [VidW-1:0] ovid_q;
  logic [ColW-1:0] ocol_q;
  logic            ost_q, olast_q;

  logic [NumW-1:0]  n_eff;
  logic [NumW-1:0]  v_ext;
  logic             vtx_last;
  logic             self_loop;
  logic             edge_bad;
  logic             adj_we;
  logic [AddrW-1:0] adj_waddr, adj_raddr;
  logic [VidW-1:0]  adj_wdata, adj_rdata;
  logic             cnt_we;
  logic [VidW-1:0]  cnt_waddr, cnt_raddr;
  logic [CntW-1:0]  cnt_wdata, cnt_rdata, cnt_val;
  logic [VidW-1:0]  col_raddr;
  logic [ColW-1:0]  col_rdata;
  logic [ColW-1:0]  hue;

  // effective count saturates at the list capacity
  assign n_eff = (count_q > NumW'(MaxVertices)) ? NumW'(MaxVertices) : count_q;
  assign v_ext = NumW'(v_q) + NumW'(1);
  assign vtx_last = (v_ext == n_eff);
  assign self_loop = (a_q == b_q);

  // a count never written reads as zero
  assign cnt_val = cnt_vld_rd_q ? cnt_rdata : '0;

  // adjacency lists, one slot per neighbor
  gdtc_ram #(.Width(VidW), .Depth(MaxVertices * MaxDegree)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  // list lengths
  gdtc_ram #(.Width(CntW), .Depth(MaxVertices)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  // colors of the current run
  gdtc_ram #(.Width(ColW), .Depth(MaxVertices)) u_col (
    .clk_i, .we_i(ctrl_i.pick), .waddr_i(v_q), .wdata_i(hue),
    .raddr_i(col_raddr), .rdata_o(col_rdata)
  );

  // adjacency write: first a's slot, next cycle b's slot (or a's next slot)
  assign adj_we = ctrl_i.edge_wr1 | ctrl_i.edge_wr2;
  always_comb begin
    if (!ctrl_i.edge_wr2) begin
      adj_waddr = {a_q, ca_q[SlotW-1:0]};
      adj_wdata = b_q;
    end else if (self_loop) begin
      adj_waddr = {a_q, SlotW'(ca_q[SlotW-1:0] + SlotW'(1))};
      adj_wdata = a_q;
    end else begin
      adj_waddr = {b_q, cb_q[SlotW-1:0]};
      adj_wdata = a_q;
    end
  end

  // count write: a with the first entry, b with the second (a self-loop writes only a)
  assign cnt_we = ctrl_i.edge_wr1 | (ctrl_i.edge_wr2 & ~self_loop);
  always_comb begin
    if (ctrl_i.edge_wr2) begin
      cnt_waddr = b_q;
      cnt_wdata = cb_q + CntW'(1);
    end else begin
      cnt_waddr = a_q;
      cnt_wdata = self_loop ? ca_q + CntW'(2) : ca_q + CntW'(1);
    end
  end

  // read addresses
  always_comb begin
    if (ctrl_i.cnt_rd_a)      cnt_raddr = a_q;
    else if (ctrl_i.cnt_rd_b) cnt_raddr = b_q;
    else if (ctrl_i.vtx_init) cnt_raddr = v_q;
    else                      cnt_raddr = adj_rdata;
  end

  always_comb begin
    if (ctrl_i.outer_rd) adj_raddr = {v_q, j_q[SlotW-1:0]};
    else                 adj_raddr = {w_q, k_q[SlotW-1:0]};
  end

  assign col_raddr = ctrl_i.emit_rd ? v_q : adj_rdata;

  // count valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      cnt_vld_rd_q <= 1'b0;
    end else begin
      if (cnt_we) cnt_vld_q[cnt_waddr] <= 1'b1;
      cnt_vld_rd_q <= cnt_vld_q[cnt_raddr];
    end
  end

  // smallest free color
  always_comb begin
    hue = ColW'(MarkSlots - 1);
    for (int i = MarkSlots - 2; i >= 0; i--) begin
      if (!marks_q[i]) hue = ColW'(i);
    end
  end

  // edge checks
  always_comb begin
    if (NumW'(a_q) >= n_eff || NumW'(b_q) >= n_eff) edge_bad = 1'b1;
    else if (self_loop) edge_bad = (5'(ca_q) + 5'd2 > 5'(MaxDegree));
    else edge_bad = (5'(ca_q) >= 5'(MaxDegree)) || (5'(cb_q) >= 5'(MaxDegree));
  end

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= NumW'(MaxVertices);
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  // input latch and endpoint counts
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      cmd_q <= cmd_i;
      a_q <= va_i;
      b_q <= vb_i;
    end
    if (ctrl_i.take_ca) ca_q <= cnt_val;
    if (ctrl_i.take_cb) cb_q <= cnt_val;
  end

  // walk indices and marks; a vertex below v_q is colored in this run
  always_ff @(posedge clk_i) begin
    if (ctrl_i.run_start) v_q <= '0;
    if (ctrl_i.pick) begin
      if (!vtx_last) v_q <= v_q + VidW'(1);
      else v_q <= '0;
    end
    if (ctrl_i.emit_next) v_q <= v_q + VidW'(1);
    if (ctrl_i.vtx_init) begin
      j_q <= '0;
      marks_q <= '0;
    end
    if (ctrl_i.take_dv) dv_q <= cnt_val;
    if (ctrl_i.outer_rd) j_q <= j_q + CntW'(1);
    if (ctrl_i.outer_take) w_q <= adj_rdata;
    if (ctrl_i.take_dw) begin
      dw_q <= cnt_val;
      k_q <= '0;
    end
    if (ctrl_i.inner_rd) k_q <= k_q + CntW'(1);
    if (ctrl_i.inner_take) x_q <= adj_rdata;
    if (ctrl_i.inner_mark) begin
      if (x_q < v_q && 32'(col_rdata) < MarkSlots)
        marks_q[col_rdata] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctrl_i.emit_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_load) begin
      if (cmd_q == CmdEdge) begin
        ovid_q <= '0;
        ocol_q <= '0;
        ost_q <= edge_bad;
        olast_q <= 1'b1;
      end else begin
        ovid_q <= v_q;
        ocol_q <= col_rdata;
        ost_q <= 1'b0;
        olast_q <= vtx_last;
      end
    end
  end

  assign out_free_o   = ~ov_q | out_ready_i;
  assign out_valid_o  = ov_q;
  assign out_vid_o    = ovid_q;
  assign out_color_o  = ocol_q;
  assign out_status_o = ost_q;
  assign out_last_o   = olast_q;

  assign stat_o.is_run      = (cmd_q == CmdRun);
  assign stat_o.edge_bad    = edge_bad;
  assign stat_o.no_vertices = (n_eff == '0);
  assign stat_o.outer_done  = (j_q >= dv_q);
  assign stat_o.inner_done  = (k_q >= dw_q);
  assign stat_o.vtx_last    = vtx_last;
endmodule

// ----- hw/rtl/greedy_distance_two_coloring_unit.sv -----
// top level of the greedy distance-two coloring unit
// depends on gdtc_pkg, gdtc_ctrl, gdtc_dp
//
// channel   dir  bits                        meaning
// s_axis    in   tdata[12:0]                 command, vertex_a, vertex_b
// m_axis    out  tdata[11:0], tuser, tlast   vertex_id, color / status
// cfg       in   cfg_data_i[6:0]             vertex_count
//
// an edge item reads both list counts, checks the edge, then waits for
// a free output; both list entries go in over two consecutive writes.
// a run walks each vertex's list and the lists of its neighbors, paced
// by the single read port of each memory, then emits one beat per vertex
// as the output stall allows.
// reset zeroes the list counts through one valid bit per vertex.
module greedy_distance_two_coloring_unit import gdtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // command, vertex_a, vertex_b, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // vertex_id, color, zero fill
  output logic        m_axis_tuser,   // status
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);
  ctrl_t ctrl;
  stat_t stat;
  logic  out_free;
  logic [VidW-1:0] ovid;
  logic [ColW-1:0] ocol;

  assign cfg_ready_o = 1'b1;

  gdtc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_free_i(out_free), .stat_i(stat), .ctrl_o(ctrl)
  );

  gdtc_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(s_axis_tdata[0]), .va_i(s_axis_tdata[6:1]), .vb_i(s_axis_tdata[12:7]),
    .cfg_we_i(cfg_valid_i), .cfg_data_i(cfg_data_i),
    .ctrl_i(ctrl), .stat_o(stat),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_free_o(out_free),
    .out_vid_o(ovid), .out_color_o(ocol), .out_status_o(m_axis_tuser),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, ocol, ovid};

  // a stalled beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("output beat changed while stalled");

  // no input taken while a vertex picks its color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pick |-> !s_axis_tready)
    else $error("input ready during coloring");

  // color results never report a dropped status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 16'd0)
    else $error("dropped status on a color beat");
endmodule
